FILE: design/mmgt_pkg.sv
// Package for the min/max gap tracker: shared widths and the token that
// travels down the row of compare cells. No dependencies.
package mmgt_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    // Token handed from cell to cell: the offered value and the running
    // smallest gap seen so far.
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic        [VALUE_W-1:0] gap;
    } token_t;

    // Exact magnitude of a - b; fits in 32 bits for any two 32-bit signed values.
    function automatic logic [VALUE_W-1:0] abs_diff(
        input logic signed [VALUE_W-1:0] a,
        input logic signed [VALUE_W-1:0] b
    );
        logic signed [VALUE_W:0] d;
        logic        [VALUE_W:0] m;
        begin
            d = {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
            m = d[VALUE_W] ? (~d + 1'b1) : d;
            abs_diff = m[VALUE_W-1:0];
        end
    endfunction

endpackage

FILE: design/mmgt_cell.sv
// One cell of the compare row: holds one stored value, checks the passing
// token against it and hands the token on. Depends on mmgt_pkg.
module mmgt_cell
    import mmgt_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COUNT_W-1:0] held_count,
    input  token_t             tok_in,
    output token_t             tok_out
);

    logic signed [VALUE_W-1:0] held_reg;
    logic                      tok_valid_reg;
    logic signed [VALUE_W-1:0] tok_value_reg;
    logic        [VALUE_W-1:0] tok_gap_reg;
    token_t                    tok_next;
    logic                      occupied;
    logic                      is_target;
    logic        [VALUE_W-1:0] gap;

    assign occupied  = 32'(INDEX) < {{(32-COUNT_W){1'b0}}, held_count};
    assign is_target = 32'(INDEX) == {{(32-COUNT_W){1'b0}}, held_count};
    assign gap       = abs_diff(tok_in.value, held_reg);

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && occupied && (gap < tok_in.gap))
        begin
            tok_next.gap = gap;
        end
    end

    // Capture the value in the first free slot as the token passes.
    always_ff @(posedge clk)
    begin
        if (tok_in.valid && is_target)
        begin
            held_reg <= tok_in.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_value_reg <= tok_next.value;
        tok_gap_reg   <= tok_next.gap;
    end

    assign tok_out = {tok_valid_reg, tok_value_reg, tok_gap_reg};

endmodule

FILE: design/min_max_gap_tracker_core.sv
// Top level of the min/max gap tracker: control, range registers, result
// register and the row of mmgt_cell compare cells. Depends on mmgt_pkg.

// Bounded store of up to min(size limit, CAPACITY) signed 32-bit values. Every
// input beat yields exactly one result beat carrying the accept/full status,
// the held count, the smallest gap between any two held values and the span
// from the smallest to the largest held value, each with its valid flag. A
// kept value is sent as a token down a row of CAPACITY cells, one cell per
// clock; each cell compares it against its own stored value, and the cell at
// the first free slot captures it. A stored value reaches the result register
// once its token has left the end of the row; a rejected value goes there
// from ST_DONE without a walk, and the load waits while the output register
// is held by out_stall. One item is worked at a time; the input stalls from
// the accepting edge until the result has moved into the output register,
// which then holds it independently of the input side. The user must write
// the size limit through cfg_wr_en / cfg_wr_data only while the block is
// idle; the block itself does not enforce this.
module min_max_gap_tracker_core
    import mmgt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [COUNT_W-1:0]        cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      status,
    output logic [COUNT_W-1:0]        count,
    output logic [VALUE_W-1:0]        shortest_span,
    output logic                      shortest_valid,
    output logic [VALUE_W-1:0]        longest_span,
    output logic                      longest_valid
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_TRAVEL = 3'b010,
        ST_DONE   = 3'b100
    } state_t;

    state_t                    state_reg, state_next;
    logic [COUNT_W-1:0]        limit_reg;
    logic [COUNT_W-1:0]        held_count_reg, held_count_next;
    logic [VALUE_W-1:0]        best_gap_reg, best_gap_next;
    logic signed [VALUE_W-1:0] low_reg, low_next;
    logic signed [VALUE_W-1:0] high_reg, high_next;
    logic                      reject_reg, reject_next;

    logic                      out_valid_reg, out_valid_next;
    logic                      status_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic [VALUE_W-1:0]        shortest_reg;
    logic                      shortest_valid_reg;
    logic [VALUE_W-1:0]        longest_reg;
    logic                      longest_valid_reg;

    logic                      accept;
    logic                      full;
    logic                      out_free;
    logic                      load_out;
    token_t                    chain [0:CAPACITY];

    // Full when the count reaches the size limit or the physical row is used up.
    assign full = (held_count_reg >= limit_reg)
               || ({{(32-COUNT_W){1'b0}}, held_count_reg} >= 32'(CAPACITY));

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = (state_reg == ST_DONE) && out_free;

    // Inject a token at the head of the row only for a kept value.
    always_comb
    begin
        chain[0].valid = accept && !full;
        chain[0].value = value;
        chain[0].gap   = best_gap_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            mmgt_cell #(
                .INDEX (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .held_count (held_count_reg),
                .tok_in     (chain[gi]),
                .tok_out    (chain[gi+1])
            );
        end
    endgenerate

    // Control and state update.
    always_comb
    begin
        state_next      = state_reg;
        held_count_next = held_count_reg;
        best_gap_next   = best_gap_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        reject_next     = reject_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    reject_next = full;
                    if (full)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_TRAVEL;
                        // Range only needs the new value; update it right away.
                        if (held_count_reg == '0)
                        begin
                            low_next  = value;
                            high_next = value;
                        end
                        else
                        begin
                            if (value < low_reg)
                            begin
                                low_next = value;
                            end
                            if (value > high_reg)
                            begin
                                high_next = value;
                            end
                        end
                    end
                end
            end
            ST_TRAVEL:
            begin
                // Token leaves the row: commit the gap and the new count.
                if (chain[CAPACITY].valid)
                begin
                    best_gap_next   = chain[CAPACITY].gap;
                    held_count_next = held_count_reg + 1'b1;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            limit_reg      <= '0;
            held_count_reg <= '0;
            best_gap_reg   <= '1;
            low_reg        <= '0;
            high_reg       <= '0;
            reject_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_count_reg <= held_count_next;
            best_gap_reg   <= best_gap_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            reject_reg     <= reject_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // Output register: advance on load, drop on a taken beat, hold otherwise.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg         <= reject_reg;
            count_reg          <= held_count_reg;
            shortest_valid_reg <= (held_count_reg >= COUNT_W'(2));
            shortest_reg       <= (held_count_reg >= COUNT_W'(2)) ? best_gap_reg : '0;
            longest_valid_reg  <= (held_count_reg != '0);
            longest_reg        <= (held_count_reg != '0) ? abs_diff(high_reg, low_reg) : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign count          = count_reg;
    assign shortest_span  = shortest_reg;
    assign shortest_valid = shortest_valid_reg;
    assign longest_span   = longest_reg;
    assign longest_valid  = longest_valid_reg;

    // A token only reaches the end of the row while an item is traveling.
    a_tail_in_travel: assert property (@(posedge clk) disable iff (!rst_n)
        chain[CAPACITY].valid |-> (state_reg == ST_TRAVEL))
        else $error("token left the row outside of travel");

    // The held count never shrinks.
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (held_count_reg >= $past(held_count_reg)))
        else $error("held count decreased");

    // Result flags agree with the reported count.
    a_flags_match_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((shortest_valid_reg == (count_reg >= COUNT_W'(2)))
                        && (longest_valid_reg == (count_reg != '0))))
        else $error("result valid flags disagree with count");

    // A rejected item leaves the count untouched.
    a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full) |=> (held_count_reg == $past(held_count_reg)))
        else $error("rejected value changed the count");

endmodule
